>>> src/iiws_pkg.sv
// Shared types and constants of the integral image block.
package iiws_pkg;

	localparam int PIXEL_W     = 8;
	localparam int CFG_W       = 7;
	localparam int AREA_W      = 20;
	localparam int SQ_W        = 28;
	localparam int LINE_W      = 20;
	localparam int LINE_SQ_W   = 29;
	localparam int WINDOW_INIT = 24;

	typedef struct packed {
		logic [AREA_W-1:0] area_sum;
		logic [SQ_W-1:0]   area_square_sum;
		logic              window_done;
	} result_t;

endpackage

>>> src/iiws_fifo.sv
// Small synchronous queue with occupancy flags decoded from a registered count.
module iiws_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CountW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [AddrW-1:0]  wr_ptr_q;
	logic [AddrW-1:0]  rd_ptr_q;
	logic [CountW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CountW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/iiws_front.sv
// Front end: window size register, position tracking and running row sums.
module iiws_front #(
	parameter int MAX_SIZE = 64,
	parameter int MID_W    = 45
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [iiws_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         accept,
	input  logic [iiws_pkg::PIXEL_W-1:0] pixel,
	output logic [MID_W-1:0]             item
);
	import iiws_pkg::*;

	localparam int ColW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SizeW   = $clog2(MAX_SIZE + 1);
	localparam int RunW    = PIXEL_W + ColW;
	localparam int RunSqW  = 2 * PIXEL_W + ColW;
	localparam int SizeRst = (WINDOW_INIT > MAX_SIZE) ? MAX_SIZE : WINDOW_INIT;

	typedef struct packed {
		logic [ColW-1:0]   col;
		logic              row_nz;
		logic              done;
		logic [RunW-1:0]   run;
		logic [RunSqW-1:0] run_sq;
	} mid_t;

	logic [SizeW-1:0]       size_q;
	logic [SizeW-1:0]       size_next;
	logic [ColW-1:0]        col_q;
	logic [ColW-1:0]        row_q;
	logic [RunW-1:0]        run_q;
	logic [RunSqW-1:0]      run_sq_q;
	logic [SizeW-1:0]       size_m1;
	logic [2*PIXEL_W-1:0]   pix_sq;
	logic                   first_col;
	logic                   last_col;
	logic                   last_row;
	mid_t                   mid;

	always_comb begin
		if (cfg_data == '0) begin
			size_next = SizeW'(1);
		end else if (32'(cfg_data) > MAX_SIZE) begin
			size_next = SizeW'(MAX_SIZE);
		end else begin
			size_next = SizeW'(cfg_data);
		end
	end

	assign size_m1   = size_q - 1'b1;
	assign first_col = (col_q == '0);
	assign last_col  = (SizeW'(col_q) == size_m1);
	assign last_row  = (SizeW'(row_q) == size_m1);
	assign pix_sq    = {{PIXEL_W{1'b0}}, pixel} * {{PIXEL_W{1'b0}}, pixel};

	always_comb begin
		mid.col    = col_q;
		mid.row_nz = (row_q != '0);
		mid.done   = last_col && last_row;
		mid.run    = (first_col ? '0 : run_q) + RunW'(pixel);
		mid.run_sq = (first_col ? '0 : run_sq_q) + RunSqW'(pix_sq);
	end

	assign item = mid;

	// A configuration write also abandons the window in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SizeW'(SizeRst);
			col_q    <= '0;
			row_q    <= '0;
			run_q    <= '0;
			run_sq_q <= '0;
		end else if (cfg_we) begin
			size_q   <= size_next;
			col_q    <= '0;
			row_q    <= '0;
			run_q    <= '0;
			run_sq_q <= '0;
		end else if (accept) begin
			run_q    <= mid.run;
			run_sq_q <= mid.run_sq;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

>>> src/iiws_back.sv
// Back end: line store read, vertical accumulation and line store update.
module iiws_back #(
	parameter int MAX_SIZE = 64,
	parameter int MID_W    = 45
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [MID_W-1:0]          item,
	input  logic                      item_empty,
	output logic                      item_pop,
	input  logic                      res_full,
	output logic                      res_push,
	output iiws_pkg::result_t         res
);
	import iiws_pkg::*;

	localparam int ColW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int RunW   = PIXEL_W + ColW;
	localparam int RunSqW = 2 * PIXEL_W + ColW;
	localparam int LineW  = LINE_W + LINE_SQ_W;

	typedef struct packed {
		logic [ColW-1:0]   col;
		logic              row_nz;
		logic              done;
		logic [RunW-1:0]   run;
		logic [RunSqW-1:0] run_sq;
	} mid_t;

	logic [LineW-1:0]     line_mem [MAX_SIZE];
	logic [LineW-1:0]     rd_q;
	logic [LineW-1:0]     last_wr_q;
	logic [LineW-1:0]     above_sel;
	mid_t                 in_item;
	mid_t                 item_s1;
	logic                 valid_s1;
	logic                 fwd_s1;
	logic                 advance;
	logic [LINE_W-1:0]    above;
	logic [LINE_SQ_W-1:0] above_sq;
	logic [LINE_W-1:0]    area;
	logic [LINE_SQ_W-1:0] area_sq;

	assign in_item  = item;
	assign advance  = !valid_s1 || !res_full;
	assign item_pop = advance && !item_empty;
	assign res_push = valid_s1 && !res_full;

	// When the stage ahead writes the same column that is being read, the
	// memory still returns the old entry, so the written value is taken instead.
	assign above_sel = fwd_s1 ? last_wr_q : rd_q;
	assign above     = item_s1.row_nz ? above_sel[LineW-1:LINE_SQ_W] : '0;
	assign above_sq  = item_s1.row_nz ? above_sel[LINE_SQ_W-1:0] : '0;
	assign area      = above + LINE_W'(item_s1.run);
	assign area_sq   = above_sq + LINE_SQ_W'(item_s1.run_sq);

	always_comb begin
		res.area_sum        = area;
		res.area_square_sum = area_sq[SQ_W-1:0];
		res.window_done     = item_s1.done;
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			rd_q <= line_mem[in_item.col];
		end
		if (res_push) begin
			line_mem[item_s1.col] <= {area, area_sq};
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			last_wr_q <= {area, area_sq};
		end
		if (advance) begin
			item_s1 <= in_item;
			fwd_s1  <= valid_s1 && (item_s1.col == in_item.col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_pop;
		end
	end

endmodule

>>> src/integral_image_with_squares_top.sv
// Integral image and squared integral image of a square pixel window.
// Pixels of a window_size x window_size window enter in raster order, and each
// yields one result: the sum of all pixels above and to the left (inclusive),
// the same sum over squared pixels, and a flag on the last pixel of the window.
// A result passes the item queue, the back end's stage register and the output
// queue. The block sustains one pixel per cycle while results are popped, set
// by the single read and single write per cycle of the line store that holds
// the previous row's integral values. Writing window_size restarts the window;
// it must be written only while no pixel is in flight. A window_size of 0 acts
// as 1, a value above MAX_SIZE acts as MAX_SIZE, and the reset value is 24.
module integral_image_with_squares_top #(
	parameter int MAX_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [iiws_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [iiws_pkg::PIXEL_W-1:0]  pixel,
	input  logic                          pop,
	output logic                          empty,
	output logic [iiws_pkg::AREA_W-1:0]   area_sum,
	output logic [iiws_pkg::SQ_W-1:0]     area_square_sum,
	output logic                          window_done
);
	import iiws_pkg::*;

	localparam int ColW      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int MidW      = ColW + 2 + (PIXEL_W + ColW) + (2 * PIXEL_W + ColW);
	localparam int QueueDep  = 2;
	localparam int ResW      = $bits(result_t);

	logic [MidW-1:0] front_item;
	logic [MidW-1:0] back_item;
	logic            accept;
	logic            item_empty;
	logic            item_pop;
	logic            res_full;
	logic            res_push;
	result_t         back_res;
	result_t         out_res;
	logic [ResW-1:0] out_bits;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	iiws_front #(
		.MAX_SIZE(MAX_SIZE),
		.MID_W   (MidW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.accept  (accept),
		.pixel   (pixel),
		.item    (front_item)
	);

	iiws_fifo #(
		.WIDTH(MidW),
		.DEPTH(QueueDep)
	) u_item_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_item),
		.full  (full),
		.pop   (item_pop),
		.rdata (back_item),
		.empty (item_empty)
	);

	iiws_back #(
		.MAX_SIZE(MAX_SIZE),
		.MID_W   (MidW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (back_item),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	iiws_fifo #(
		.WIDTH(ResW),
		.DEPTH(QueueDep)
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_bits),
		.empty (empty)
	);

	assign out_res         = out_bits;
	assign area_sum        = out_res.area_sum;
	assign area_square_sum = out_res.area_square_sum;
	assign window_done     = out_res.window_done;

endmodule

>>> dv/integral_image_with_squares_top_test.sv
// Self-checking testbench for the integral image and squared integral image block.
`timescale 1ns / 100ps

module integral_image_with_squares_top_test;
	import iiws_pkg::*;

	localparam int LINE_DEPTH      = 64;
	localparam int CLK_PERIOD      = 8;
	localparam int IDLE_PCT        = 38;
	localparam int WIDE_ROWS       = 4;
	localparam int RANDOM_PIXELS   = 970;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_CYCLES = 250_000;
	localparam int REPORT_LIMIT    = 10;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;
	logic                push;
	logic                full;
	logic [PIXEL_W-1:0]  pixel;
	logic                pop;
	logic                empty;
	logic [AREA_W-1:0]   area_sum;
	logic [SQ_W-1:0]     area_square_sum;
	logic                window_done;

	integral_image_with_squares_top #(
		.MAX_SIZE(LINE_DEPTH)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.pixel          (pixel),
		.pop            (pop),
		.empty          (empty),
		.area_sum       (area_sum),
		.area_square_sum(area_square_sum),
		.window_done    (window_done)
	);

	// Mirror of the block's window state.
	logic [CFG_W-1:0]     win_reg;
	logic [LINE_W-1:0]    line_sums        [LINE_DEPTH];
	logic [LINE_SQ_W-1:0] line_square_sums [LINE_DEPTH];
	logic [13:0]          row_run;
	logic [21:0]          row_run_sq;
	int unsigned          row_pos;
	int unsigned          col_pos;

	result_t pending_sums [$];
	int      failures;
	bit      steady_flow;
	bit      backpressure_req;

	typedef struct {
		bit               set_size;
		logic [CFG_W-1:0] size;
		logic [PIXEL_W-1:0] pix;
		bit               typed;
		result_t          want;
	} dir_row_t;

	// Rows with typed results are easy to work out by hand; the rest use the predictor.
	dir_row_t directed_rows [21] = '{
		'{1'b0, 7'd0,   8'd255, 1'b1, {20'd255,  28'd65025,  1'b0}},
		'{1'b0, 7'd0,   8'd0,   1'b1, {20'd255,  28'd65025,  1'b0}},
		'{1'b0, 7'd0,   8'd90,  1'b0, '0},
		'{1'b1, 7'd0,   8'd255, 1'b1, {20'd255,  28'd65025,  1'b1}},
		'{1'b0, 7'd0,   8'd0,   1'b1, {20'd0,    28'd0,      1'b1}},
		'{1'b0, 7'd0,   8'd170, 1'b1, {20'd170,  28'd28900,  1'b1}},
		'{1'b0, 7'd0,   8'd85,  1'b1, {20'd85,   28'd7225,   1'b1}},
		'{1'b1, 7'd1,   8'd1,   1'b1, {20'd1,    28'd1,      1'b1}},
		'{1'b1, 7'd2,   8'd255, 1'b1, {20'd255,  28'd65025,  1'b0}},
		'{1'b0, 7'd0,   8'd255, 1'b1, {20'd510,  28'd130050, 1'b0}},
		'{1'b0, 7'd0,   8'd255, 1'b1, {20'd510,  28'd130050, 1'b0}},
		'{1'b0, 7'd0,   8'd255, 1'b1, {20'd1020, 28'd260100, 1'b1}},
		'{1'b0, 7'd0,   8'd0,   1'b1, {20'd0,    28'd0,      1'b0}},
		'{1'b1, 7'd127, 8'd255, 1'b0, '0},
		'{1'b0, 7'd0,   8'd17,  1'b0, '0},
		'{1'b0, 7'd0,   8'd240, 1'b0, '0},
		'{1'b1, 7'd65,  8'd1,   1'b0, '0},
		'{1'b0, 7'd0,   8'd128, 1'b0, '0},
		'{1'b1, 7'd64,  8'd254, 1'b0, '0},
		'{1'b0, 7'd0,   8'd127, 1'b0, '0},
		'{1'b1, 7'd24,  8'd99,  1'b0, '0}
	};

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > LINE_DEPTH)
			return LINE_DEPTH;
		return 32'(v);
	endfunction

	task automatic restart_window_state();
		row_run    = '0;
		row_run_sq = '0;
		row_pos    = 0;
		col_pos    = 0;
	endtask

	task automatic apply_window_size(input logic [CFG_W-1:0] v);
		win_reg = v;
		restart_window_state();
	endtask

	task automatic integrate_pixel(input logic [PIXEL_W-1:0] p, output result_t sums);
		int unsigned size;
		int unsigned c;
		logic [31:0] total;
		logic [31:0] total_sq;
		size = clamp_size(win_reg);
		c = col_pos;
		if (c >= size || row_pos >= size) begin
			restart_window_state();
			c = 0;
		end
		if (c == 0) begin
			row_run    = '0;
			row_run_sq = '0;
		end
		row_run    += 14'(p);
		row_run_sq += 22'(p) * 22'(p);
		total    = 32'(row_run);
		total_sq = 32'(row_run_sq);
		// The first row of a window has nothing above it.
		if (row_pos > 0) begin
			total    += 32'(line_sums[c]);
			total_sq += 32'(line_square_sums[c]);
		end
		line_sums[c]        = LINE_W'(total);
		line_square_sums[c] = LINE_SQ_W'(total_sq);
		sums.area_sum        = AREA_W'(total);
		sums.area_square_sum = SQ_W'(total_sq);
		sums.window_done     = (row_pos == size - 1) && (c == size - 1);
		if (c == size - 1) begin
			col_pos = 0;
			row_pos = sums.window_done ? 0 : row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	task automatic push_pixel(input logic [PIXEL_W-1:0] p, input bit typed, input result_t typed_sums);
		result_t predicted;
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
		integrate_pixel(p, predicted);
		pending_sums.push_back(typed ? typed_sums : predicted);
	endtask

	task automatic sender_gap();
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			push  <= 1'b0;
			pixel <= 8'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic wait_for_idle();
		push <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		apply_window_size(v);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("[integral_image_with_squares_top] ERROR");
		$finish;
	end

	initial begin : result_sink
		int unsigned hold_cycles;
		bit          held_once;
		result_t     got;
		result_t     want;
		hold_cycles = 0;
		held_once   = 1'b0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {area_sum, area_square_sum, window_done};
				if (pending_sums.size() == 0) begin
					log_failure($sformatf("unexpected result: area_sum %0d area_square_sum %0d done %0b",
						got.area_sum, got.area_square_sum, got.window_done));
				end else begin
					want = pending_sums.pop_front();
					if (got.area_sum !== want.area_sum)
						log_failure($sformatf("area_sum: expected %0d, got %0d",
							want.area_sum, got.area_sum));
					if (got.area_square_sum !== want.area_square_sum)
						log_failure($sformatf("area_square_sum: expected %0d, got %0d",
							want.area_square_sum, got.area_square_sum));
					if (got.window_done !== want.window_done)
						log_failure($sformatf("window_done: expected %0b, got %0b",
							want.window_done, got.window_done));
				end
			end
			// One long hold-off lets the block fill up and push back on its input.
			if (backpressure_req && !held_once) begin
				hold_cycles = HOLD_OFF_CYCLES;
				held_once   = 1'b1;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else if (steady_flow) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		int unsigned      random_items;
		int unsigned      eff;
		int unsigned      n;
		int unsigned      r;
		logic [CFG_W-1:0] size_code;
		failures         = 0;
		steady_flow      = 1'b0;
		backpressure_req = 1'b0;
		apply_window_size(7'(WINDOW_INIT));
		arst_n    <= 1'b0;
		push      <= 1'b0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_size) begin
				wait_for_idle();
				write_size(directed_rows[i].size);
			end
			sender_gap();
			push_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
		end

		// A few full-width rows of white pixels at the largest size sweep the
		// whole line store.
		wait_for_idle();
		write_size(7'(LINE_DEPTH));
		backpressure_req = 1'b1;
		for (int i = 0; i < LINE_DEPTH * WIDE_ROWS; i++) begin
			steady_flow = (i >= LINE_DEPTH * WIDE_ROWS / 2);
			sender_gap();
			push_pixel(8'hFF, 1'b0, '0);
		end
		steady_flow = 1'b0;

		random_items = 0;
		while (random_items < RANDOM_PIXELS) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				size_code = 7'($urandom_range(1, 8));
			else if (r < 75)
				size_code = 7'($urandom_range(9, LINE_DEPTH - 1));
			else if (r < 85)
				size_code = '0;
			else if (r < 95)
				size_code = 7'($urandom_range(LINE_DEPTH + 1, 127));
			else
				size_code = 7'(LINE_DEPTH);
			wait_for_idle();
			write_size(size_code);
			eff = clamp_size(size_code);
			// Small windows run to completion, sometimes with a partial one left
			// hanging; large windows are cut short by the next register write.
			if (eff <= 8) begin
				n = $urandom_range(1, 3) * eff * eff;
				if (eff > 1 && $urandom_range(0, 3) == 0)
					n += $urandom_range(1, eff * eff - 1);
			end else begin
				n = $urandom_range(1, 3 * eff);
			end
			repeat (n) begin
				r = $urandom_range(0, 99);
				sender_gap();
				push_pixel((r < 15) ? 8'd0 : (r < 30) ? 8'hFF : 8'($urandom), 1'b0, '0);
			end
			random_items += n;
		end

		wait_for_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending_sums.size() == 0) begin
			$display("[integral_image_with_squares_top] OK");
		end else begin
			$display("[integral_image_with_squares_top] ERROR");
		end
		$finish;
	end

endmodule
